// ===== design/arm_unwind_opcode_engine_unit_macros.svh =====
// Assertion macros shared by the unwind engine checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ARM_UNWIND_OPCODE_ENGINE_UNIT_MACROS_SVH
`define ARM_UNWIND_OPCODE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AUOE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AUOE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ===== design/auoe_pkg.sv =====
// Types and constants for the unwind opcode engine.
// Used by auoe_exec, arm_unwind_opcode_engine_unit, auoe_checker and the testbench; depends on nothing.
package auoe_pkg;

	// Input word codes.
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_OPCODE = 2'd1;
	localparam logic [1:0] FUNC_WORD = 2'd2;
	localparam logic [1:0] FUNC_READ = 2'd3;

	// Result kinds.
	localparam logic [2:0] KIND_OK = 3'd0;
	localparam logic [2:0] KIND_REQ = 3'd1;
	localparam logic [2:0] KIND_VAL = 3'd2;
	localparam logic [2:0] KIND_FIN = 3'd3;
	localparam logic [2:0] KIND_ERR = 3'd4;

	// Frame status codes.
	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [1:0] ST_ERR = 2'd3;

	// Register numbers with fixed roles.
	localparam logic [3:0] REG_SP = 4'd13;
	localparam logic [3:0] REG_LR = 4'd14;
	localparam logic [3:0] REG_PC = 4'd15;

	// Opcode patterns.
	localparam logic [1:0] OP_INC_HI = 2'b00;
	localparam logic [1:0] OP_DEC_HI = 2'b01;
	localparam logic [3:0] OP_POP_MASK_HI = 4'h8;
	localparam logic [3:0] OP_SET_SP_HI = 4'h9;
	localparam logic [3:0] OP_POP_SHORT_HI = 4'ha;
	localparam logic [7:0] OP_FINISH = 8'hb0;
	localparam logic [7:0] OP_LARGE_INC = 8'hb2;
	localparam logic [31:0] LARGE_INC_BASE = 32'h0000_0204;

	typedef struct packed {
		logic [1:0] func;
		logic [3:0] reg_index;
		logic [31:0] data;
	} in_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [31:0] read_address;
		logic [3:0] word_count;
		logic [31:0] value;
		logic [15:0] updated_regs;
	} out_t;

	// Per-frame unwind state.
	typedef struct packed {
		logic [15:0] loaded_mask;
		logic [7:0] pending_opcode;
		logic awaiting_second_byte;
		logic [15:0] pop_list;
		logic [31:0] pop_pointer;
		logic sp_was_popped;
		logic [1:0] frame_status;
	} frame_t;

	// Register file writes for one word: a general port and the SP port.
	typedef struct packed {
		logic a_en;
		logic [3:0] a_idx;
		logic [31:0] a_data;
		logic sp_en;
		logic [31:0] sp_data;
	} rf_wr_t;

endpackage

// ===== design/auoe_exec.sv =====
// Combinational execute logic: decodes one word against the frame state
// and register file. Depends on auoe_pkg.
module auoe_exec (
	input auoe_pkg::in_t item,
	input auoe_pkg::frame_t fr,
	input logic [31:0] regs [16],
	output auoe_pkg::frame_t fr_nxt,
	output auoe_pkg::rf_wr_t wr,
	output auoe_pkg::out_t res
);

	logic [7:0] b;
	logic [31:0] sp;
	logic [31:0] lr;
	logic [3:0] rd_idx;
	logic [31:0] rd_val;
	logic [3:0] first_idx;
	logic [15:0] first_bit;
	logic [15:0] list_left;
	logic [31:0] ptr_inc;
	logic [11:0] mask12;
	logic [15:0] list_short;
	logic [15:0] pop_src;
	logic [2:0] nib_cnt [4];
	logic [3:0] pop_cnt;
	logic [31:0] sp_step;
	logic [2:0] kind;
	logic [31:0] addr;
	logic [3:0] count;
	logic [31:0] value;

	// Operand selection and register reads.
	assign b = item.data[7:0];
	assign sp = regs[auoe_pkg::REG_SP];
	assign lr = regs[auoe_pkg::REG_LR];
	assign rd_idx = (item.func == auoe_pkg::FUNC_READ) ? item.reg_index : b[3:0];
	assign rd_val = regs[rd_idx];

	// Lowest pending register of the current pop.
	always_comb begin
		first_idx = auoe_pkg::REG_PC;
		for (int i = 15; i >= 0; i--) begin
			if (fr.pop_list[i]) begin
				first_idx = 4'(i);
			end
		end
	end

	assign first_bit = 16'd1 << first_idx;
	assign list_left = fr.pop_list & ~first_bit;
	assign ptr_inc = fr.pop_pointer + 32'd4;

	// Register lists for the two pop forms.
	assign mask12 = {fr.pending_opcode[3:0], b};
	always_comb begin
		list_short = '0;
		for (int i = 0; i < 8; i++) begin
			list_short[4 + i] = (3'(i) <= b[2:0]);
		end
		list_short[auoe_pkg::REG_LR] = b[3];
	end
	assign pop_src = fr.awaiting_second_byte ? {mask12, 4'b0000} : list_short;

	// Word count as a two-level population count.
	always_comb begin
		for (int n = 0; n < 4; n++) begin
			nib_cnt[n] = 3'(pop_src[4*n]) + 3'(pop_src[4*n+1])
				+ 3'(pop_src[4*n+2]) + 3'(pop_src[4*n+3]);
		end
		pop_cnt = 4'(nib_cnt[0]) + 4'(nib_cnt[1]) + 4'(nib_cnt[2]) + 4'(nib_cnt[3]);
	end

	assign sp_step = {24'd0, b[5:0], 2'b00} + 32'd4;

	// Main decode and state update.
	always_comb begin
		fr_nxt = fr;
		wr = '0;
		kind = auoe_pkg::KIND_OK;
		addr = '0;
		count = '0;
		value = '0;
		unique case (item.func)
			auoe_pkg::FUNC_WRITE: begin
				wr.a_en = 1'b1;
				wr.a_idx = item.reg_index;
				wr.a_data = item.data;
				fr_nxt = '0;
				fr_nxt.frame_status = auoe_pkg::ST_RUN;
			end
			auoe_pkg::FUNC_READ: begin
				kind = auoe_pkg::KIND_VAL;
				value = rd_val;
			end
			auoe_pkg::FUNC_WORD: begin
				if (fr.frame_status == auoe_pkg::ST_WAIT && fr.pop_list != '0) begin
					wr.a_en = 1'b1;
					wr.a_idx = first_idx;
					wr.a_data = item.data;
					fr_nxt.loaded_mask = fr.loaded_mask | first_bit;
					fr_nxt.pop_list = list_left;
					fr_nxt.pop_pointer = ptr_inc;
					if (list_left == '0) begin
						wr.sp_en = !fr.sp_was_popped;
						wr.sp_data = ptr_inc;
						fr_nxt.frame_status = auoe_pkg::ST_RUN;
					end
				end else begin
					kind = auoe_pkg::KIND_ERR;
				end
			end
			auoe_pkg::FUNC_OPCODE: begin
				if (fr.frame_status != auoe_pkg::ST_RUN) begin
					kind = auoe_pkg::KIND_ERR;
				end else if (fr.awaiting_second_byte) begin
					fr_nxt.awaiting_second_byte = 1'b0;
					if (fr.pending_opcode == auoe_pkg::OP_LARGE_INC) begin
						wr.sp_en = 1'b1;
						wr.sp_data = sp + auoe_pkg::LARGE_INC_BASE + {22'd0, b, 2'b00};
					end else if (mask12 == '0) begin
						// A pop with an empty mask means refuse to unwind.
						kind = auoe_pkg::KIND_ERR;
					end else begin
						kind = auoe_pkg::KIND_REQ;
						addr = sp;
						count = pop_cnt;
						fr_nxt.pop_list = pop_src;
						fr_nxt.pop_pointer = sp;
						fr_nxt.sp_was_popped = pop_src[auoe_pkg::REG_SP];
						fr_nxt.frame_status = auoe_pkg::ST_WAIT;
					end
				end else begin
					priority if (b[7:6] == auoe_pkg::OP_INC_HI) begin
						wr.sp_en = 1'b1;
						wr.sp_data = sp + sp_step;
					end else if (b[7:6] == auoe_pkg::OP_DEC_HI) begin
						wr.sp_en = 1'b1;
						wr.sp_data = sp - sp_step;
					end else if (b[7:4] == auoe_pkg::OP_POP_MASK_HI
						|| b == auoe_pkg::OP_LARGE_INC) begin
						fr_nxt.pending_opcode = b;
						fr_nxt.awaiting_second_byte = 1'b1;
					end else if (b[7:4] == auoe_pkg::OP_SET_SP_HI
						&& b[3:0] != auoe_pkg::REG_SP && b[3:0] != auoe_pkg::REG_PC) begin
						wr.sp_en = 1'b1;
						wr.sp_data = rd_val;
					end else if (b[7:4] == auoe_pkg::OP_POP_SHORT_HI) begin
						kind = auoe_pkg::KIND_REQ;
						addr = sp;
						count = pop_cnt;
						fr_nxt.pop_list = pop_src;
						fr_nxt.pop_pointer = sp;
						fr_nxt.sp_was_popped = pop_src[auoe_pkg::REG_SP];
						fr_nxt.frame_status = auoe_pkg::ST_WAIT;
					end else if (b == auoe_pkg::OP_FINISH) begin
						// PC takes LR unless it came off the stack.
						wr.a_en = !fr.loaded_mask[15];
						wr.a_idx = auoe_pkg::REG_PC;
						wr.a_data = lr;
						fr_nxt.frame_status = auoe_pkg::ST_DONE;
						kind = auoe_pkg::KIND_FIN;
					end else begin
						kind = auoe_pkg::KIND_ERR;
					end
				end
			end
			default: begin
				kind = auoe_pkg::KIND_ERR;
			end
		endcase

		// Any error stops the frame and drops pending work.
		if (kind == auoe_pkg::KIND_ERR) begin
			fr_nxt.frame_status = auoe_pkg::ST_ERR;
			fr_nxt.awaiting_second_byte = 1'b0;
			fr_nxt.pop_list = '0;
		end
	end

	// Result word.
	always_comb begin
		res.kind = kind;
		res.read_address = addr;
		res.word_count = count;
		res.value = value;
		res.updated_regs = fr_nxt.loaded_mask;
	end

endmodule

// ===== design/arm_unwind_opcode_engine_unit.sv =====
// Unwind opcode engine, top level: input register, frame state, register file
// and result register around auoe_exec. Depends on auoe_pkg and auoe_exec.
//
// Each accepted input word produces exactly one result word: the execute logic
// works on the word while it sits in the input register, and the result
// register loads the result when the output side is not stalled. The engine
// sustains one word per cycle while the output side is not stalled; the execute
// step decodes the word and updates the 16-entry register file and the frame
// state in the same cycle. A new word is accepted while a finished result still
// waits in the result register, as long as the input register is empty or can
// move forward. There is no clearing pass: reset clears the valid flags, the
// frame state and the register file at once.
module arm_unwind_opcode_engine_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input auoe_pkg::in_t in_item,
	output logic out_valid,
	input logic out_ready,
	output auoe_pkg::out_t out_item
);

	logic valid_s1;
	auoe_pkg::in_t item_s1;
	logic advance;
	auoe_pkg::frame_t frame_q;
	auoe_pkg::frame_t frame_nxt;
	logic [31:0] regs_q [16];
	auoe_pkg::rf_wr_t wr;
	auoe_pkg::out_t res;

	// Handshake: execute moves when the result register is free or draining.
	assign advance = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// Execute logic.
	auoe_exec u_exec (
		.item(item_s1),
		.fr(frame_q),
		.regs(regs_q),
		.fr_nxt(frame_nxt),
		.wr(wr),
		.res(res)
	);

	// Frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
		end else if (advance) begin
			frame_q <= frame_nxt;
		end
	end

	// Register file, one general write port and one SP port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				regs_q[i] <= '0;
			end
		end else if (advance) begin
			for (int i = 0; i < 16; i++) begin
				if (wr.sp_en && 4'(i) == auoe_pkg::REG_SP) begin
					regs_q[i] <= wr.sp_data;
				end else if (wr.a_en && wr.a_idx == 4'(i)) begin
					regs_q[i] <= wr.a_data;
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_item <= res;
		end
	end

endmodule

// ===== design/auoe_checker.sv =====
// Port-level checker for the unwind opcode engine and its bind statement.
// Depends on auoe_pkg and arm_unwind_opcode_engine_unit_macros.svh.
`include "arm_unwind_opcode_engine_unit_macros.svh"

module auoe_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input auoe_pkg::out_t out_item
);

	// A stalled result word holds.
	`AUOE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item), "result word changed while stalled")

	// The input side only stalls behind a held result word.
	`AUOE_ASSERT_NOW(a_in_stall, clk, arst_n, !in_ready, out_valid && !out_ready, "input stalled without a stalled result")

	// Only stack read requests carry an address and a count.
	`AUOE_ASSERT_NOW(a_req_fields, clk, arst_n, out_valid && out_item.kind != auoe_pkg::KIND_REQ, out_item.word_count == 4'd0 && out_item.read_address == 32'd0, "address or count on a non-request word")

	// A stack read request asks for at least one word.
	`AUOE_ASSERT_NOW(a_req_count, clk, arst_n, out_valid && out_item.kind == auoe_pkg::KIND_REQ, out_item.word_count != 4'd0, "empty stack read request")

	// Only register reads carry a value.
	`AUOE_ASSERT_NOW(a_val_field, clk, arst_n, out_valid && out_item.kind != auoe_pkg::KIND_VAL, out_item.value == 32'd0, "value on a non-read word")

endmodule

bind arm_unwind_opcode_engine_unit auoe_checker u_auoe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item(out_item)
);

// ===== tb/sv/auoe_tb_pkg.sv =====
`timescale 1ns / 100ps
// Result tracker for the unwind opcode engine testbench: a cycle-free model of
// the engine's frame state and register file plus the queue of predicted results.
// Depends on auoe_pkg for the word types and the function, kind and status codes.
package auoe_tb_pkg;
	import auoe_pkg::*;

	class unwind_tracker;
		logic [31:0] regs [16];
		logic [15:0] loaded;
		logic [7:0] held_op;
		bit second_byte_due;
		logic [15:0] pop_left;
		logic [31:0] pop_addr;
		bit sp_popped;
		logic [1:0] status;
		out_t replies_due [$];
		int unsigned failures;

		function new();
			foreach (regs[i]) regs[i] = '0;
			failures = 0;
			clear_frame();
		endfunction

		// A register write starts a fresh frame.
		function void clear_frame();
			loaded = '0;
			held_op = '0;
			second_byte_due = 1'b0;
			pop_left = '0;
			pop_addr = '0;
			sp_popped = 1'b0;
			status = ST_RUN;
		endfunction

		// Arm a pop of the listed registers and return the number of words it needs.
		function int unsigned start_pop(logic [15:0] list);
			pop_left = list;
			pop_addr = regs[REG_SP];
			sp_popped = list[REG_SP];
			status = ST_WAIT;
			return $countones(list);
		endfunction

		function bit waiting_for_words();
			return status == ST_WAIT && pop_left != '0;
		endfunction

		function int unsigned outstanding();
			return replies_due.size();
		endfunction

		// Apply one accepted input word and queue the result it must produce.
		function void take_input(in_t it);
			out_t r;
			logic [7:0] b;
			logic [11:0] mask;
			logic [15:0] list;
			int unsigned slot;
			int unsigned n;
			r = '0;
			r.kind = KIND_OK;
			b = it.data[7:0];
			case (it.func)
				FUNC_WRITE: begin
					regs[it.reg_index] = it.data;
					clear_frame();
				end
				FUNC_READ: begin
					r.kind = KIND_VAL;
					r.value = regs[it.reg_index];
				end
				FUNC_WORD: begin
					if (status == ST_WAIT && pop_left != '0) begin
						// Words fill the lowest outstanding register first.
						slot = 0;
						while (slot < 15 && !pop_left[slot])
							slot++;
						regs[slot] = it.data;
						loaded[slot] = 1'b1;
						pop_left[slot] = 1'b0;
						pop_addr += 32'd4;
						if (pop_left == '0) begin
							if (!sp_popped)
								regs[REG_SP] = pop_addr;
							status = ST_RUN;
						end
					end else begin
						r.kind = KIND_ERR;
					end
				end
				default: begin
					if (status != ST_RUN) begin
						r.kind = KIND_ERR;
					end else if (second_byte_due) begin
						second_byte_due = 1'b0;
						if (held_op == OP_LARGE_INC) begin
							regs[REG_SP] += LARGE_INC_BASE + {22'd0, b, 2'b00};
						end else begin
							mask = {held_op[3:0], b};
							if (mask == '0) begin
								r.kind = KIND_ERR;
							end else begin
								r.kind = KIND_REQ;
								r.read_address = regs[REG_SP];
								r.word_count = 4'(start_pop({mask, 4'd0}));
							end
						end
					end else if (b[7:6] == OP_INC_HI) begin
						regs[REG_SP] += {24'd0, b[5:0], 2'b00} + 32'd4;
					end else if (b[7:6] == OP_DEC_HI) begin
						regs[REG_SP] -= {24'd0, b[5:0], 2'b00} + 32'd4;
					end else if (b[7:4] == OP_POP_MASK_HI || b == OP_LARGE_INC) begin
						held_op = b;
						second_byte_due = 1'b1;
					end else if (b[7:4] == OP_SET_SP_HI && b[3:0] != REG_SP &&
							b[3:0] != REG_PC) begin
						regs[REG_SP] = regs[b[3:0]];
					end else if (b[7:4] == OP_POP_SHORT_HI) begin
						// r4 up to r4+n, with bit 3 adding the link register.
						n = b[2:0];
						list = 16'(((32'd1 << (n + 1)) - 32'd1) << 4);
						if (b[3])
							list[REG_LR] = 1'b1;
						r.kind = KIND_REQ;
						r.read_address = regs[REG_SP];
						r.word_count = 4'(start_pop(list));
					end else if (b == OP_FINISH) begin
						if (!loaded[REG_PC])
							regs[REG_PC] = regs[REG_LR];
						status = ST_DONE;
						r.kind = KIND_FIN;
					end else begin
						r.kind = KIND_ERR;
					end
				end
			endcase
			if (r.kind == KIND_ERR) begin
				status = ST_ERR;
				second_byte_due = 1'b0;
				pop_left = '0;
			end
			r.updated_regs = loaded;
			replies_due.push_back(r);
		endfunction

		// Compare one accepted result word with the oldest prediction.
		function void check_result(out_t got);
			out_t want;
			if (replies_due.size() == 0) begin
				if (failures < 10)
					$display("Unexpected result: kind %0d addr %h count %0d value %h regs %h",
						got.kind, got.read_address, got.word_count, got.value,
						got.updated_regs);
				failures++;
				return;
			end
			want = replies_due.pop_front();
			if (got.kind !== want.kind || got.read_address !== want.read_address ||
					got.word_count !== want.word_count || got.value !== want.value ||
					got.updated_regs !== want.updated_regs) begin
				if (failures < 10) begin
					$display("Result mismatch, expected: kind %0d addr %h count %0d value %h regs %h",
						want.kind, want.read_address, want.word_count, want.value,
						want.updated_regs);
					$display("                    actual: kind %0d addr %h count %0d value %h regs %h",
						got.kind, got.read_address, got.word_count, got.value,
						got.updated_regs);
				end
				failures++;
			end
		endfunction
	endclass

endpackage

// ===== tb/sv/arm_unwind_opcode_engine_unit_tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench for arm_unwind_opcode_engine_unit: directed and random unwind
// frames with random idling on both sides. Depends on auoe_pkg and auoe_tb_pkg.
module arm_unwind_opcode_engine_unit_tb;
	import auoe_pkg::*;
	import auoe_tb_pkg::*;

	localparam int unsigned ITEM_TARGET = 850;
	localparam int unsigned CALM_TAIL = 100;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES = 8;
	// Opcode bytes outside the supported set.
	localparam logic [7:0] OP_SPARE_B1 = 8'hb1;
	localparam logic [7:0] OP_SPARE_FIRST = 8'hb3;
	localparam logic [7:0] OP_SPARE_LAST = 8'hff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_item;

	unwind_tracker tracker;
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;
	int unsigned gap_odds = 4;
	int unsigned stall_odds = 4;
	bit calm = 1'b0;

	arm_unwind_opcode_engine_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Idle odds: zero means no idling, otherwise one chance in odds+1 per word.
	function automatic int unsigned pick_idle_odds();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 2;
			2: return 6;
			default: return 12;
		endcase
	endfunction

	// Present one word, hold it until accepted, then record it.
	task automatic drive_word(logic [1:0] func, logic [3:0] idx, logic [31:0] data);
		in_t it;
		it.func = func;
		it.reg_index = idx;
		it.data = data;
		@(negedge clk);
		if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.take_input(it);
		items_sent++;
		if (items_sent >= ITEM_TARGET - CALM_TAIL)
			calm = 1'b1;
	endtask

	// Opcode bytes carry random upper bits and a random register index.
	task automatic send_opcode(logic [7:0] op);
		logic [31:0] w;
		w = $urandom();
		w[7:0] = op;
		drive_word(FUNC_OPCODE, 4'($urandom_range(0, 15)), w);
	endtask

	task automatic send_read();
		drive_word(FUNC_READ, 4'($urandom_range(0, 15)), $urandom());
	endtask

	// Hold off the sender until every predicted result has come back.
	task automatic wait_for_replies();
		@(negedge clk);
		in_valid <= 1'b0;
		while (tracker.outstanding() != 0)
			@(negedge clk);
	endtask

	// One opcode from the supported set, now and then a faulty one.
	task automatic send_random_opcode();
		int unsigned pick;
		logic [3:0] r;
		pick = $urandom_range(0, 99);
		if (pick < 18) begin
			send_opcode({OP_INC_HI, 6'($urandom_range(0, 63))});
		end else if (pick < 34) begin
			send_opcode({OP_DEC_HI, 6'($urandom_range(0, 63))});
		end else if (pick < 50) begin
			if ($urandom_range(0, 19) == 0) begin
				send_opcode({OP_POP_MASK_HI, 4'd0});
				send_opcode(8'd0);
			end else begin
				send_opcode({OP_POP_MASK_HI, 4'($urandom_range(0, 15))});
				send_opcode(8'($urandom_range(0, 255)));
			end
		end else if (pick < 62) begin
			r = 4'($urandom_range(0, 15));
			if ((r == REG_SP || r == REG_PC) && $urandom_range(0, 4) != 0)
				r = 4'($urandom_range(0, 12));
			send_opcode({OP_SET_SP_HI, r});
		end else if (pick < 80) begin
			send_opcode({OP_POP_SHORT_HI, 4'($urandom_range(0, 15))});
		end else if (pick < 97) begin
			send_opcode(OP_LARGE_INC);
			send_opcode(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 3))
				0: send_opcode({OP_SET_SP_HI, REG_SP});
				1: send_opcode({OP_SET_SP_HI, REG_PC});
				2: send_opcode(OP_SPARE_B1);
				default: send_opcode(8'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)));
			endcase
		end
	endtask

	// A well-formed frame: register setup, opcodes with their stack words, finish.
	task automatic run_unwind_frame();
		int unsigned ops;
		int unsigned feed;
		repeat ($urandom_range(1, 4))
			drive_word(FUNC_WRITE, 4'($urandom_range(0, 15)), $urandom());
		ops = $urandom_range(1, 8);
		repeat (ops) begin
			if ($urandom_range(0, 9) == 0)
				send_read();
			send_random_opcode();
			// Occasionally cut a pop short so the next opcode hits a waiting frame.
			if (tracker.waiting_for_words() && $urandom_range(0, 24) == 0)
				feed = $urandom_range(0, $countones(tracker.pop_left) - 1);
			else
				feed = 16;
			while (tracker.waiting_for_words() && feed != 0) begin
				if ($urandom_range(0, 19) == 0)
					send_read();
				drive_word(FUNC_WORD, 4'($urandom_range(0, 15)), $urandom());
				feed--;
			end
		end
		if ($urandom_range(0, 9) != 0)
			send_opcode(OP_FINISH);
		repeat ($urandom_range(0, 2))
			send_read();
	endtask

	// Result side: ready drops in random bursts, with quiet stretches between.
	always begin
		@(negedge clk);
		if ($urandom_range(0, 49) == 0)
			stall_odds = pick_idle_odds();
		if (!calm && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		out_ready <= 1'b1;
	end

	// Check every accepted result and watch for a stalled handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				tracker.check_result(out_item);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[arm_unwind_opcode_engine_unit] ERROR");
				$finish;
			end
		end
	end

	initial begin
		tracker = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Stack pointer arithmetic at the wrap points.
		drive_word(FUNC_WRITE, REG_SP, 32'hffff_fffc);
		drive_word(FUNC_WRITE, 4'd4, 32'h0000_1000);
		send_opcode({OP_INC_HI, 6'h00});
		send_opcode({OP_DEC_HI, 6'h3f});
		send_opcode({OP_INC_HI, 6'h3f});
		send_opcode(OP_LARGE_INC);
		send_opcode(8'hff);
		send_opcode({OP_SET_SP_HI, 4'd4});
		// Short pop of r4 with the link register, then SP moves past the words.
		send_opcode({OP_POP_SHORT_HI, 4'b1000});
		drive_word(FUNC_WORD, 4'd0, 32'hffff_ffff);
		drive_word(FUNC_WORD, 4'd15, 32'h0000_0000);
		// Refusal to unwind, then an opcode and a stack word in the error state.
		send_opcode({OP_POP_MASK_HI, 4'h0});
		send_opcode(8'h00);
		send_opcode({OP_INC_HI, 6'h01});
		drive_word(FUNC_WORD, 4'd0, 32'h1234_5678);
		// Masked pop of SP and PC: SP keeps the popped value and finish leaves PC.
		drive_word(FUNC_WRITE, REG_SP, 32'h0000_2000);
		send_opcode({OP_POP_MASK_HI, 4'ha});
		send_opcode(8'h00);
		drive_word(FUNC_WORD, 4'd0, 32'ha5a5_a5a5);
		drive_word(FUNC_WORD, 4'd0, 32'h5a5a_5a5a);
		send_opcode(OP_FINISH);
		send_opcode({OP_INC_HI, 6'h00});
		// Finish without a popped PC copies the link register.
		drive_word(FUNC_WRITE, REG_LR, 32'h8000_0001);
		send_opcode(OP_FINISH);
		drive_word(FUNC_READ, REG_PC, 32'h0000_0000);
		// Opcodes with no meaning.
		drive_word(FUNC_WRITE, 4'd0, 32'hffff_ffff);
		send_opcode({OP_SET_SP_HI, REG_SP});
		drive_word(FUNC_WRITE, 4'd1, 32'h0000_0000);
		send_opcode(OP_SPARE_B1);
		wait_for_replies();

		// Random frames mixed with stray words.
		while (items_sent < ITEM_TARGET) begin
			gap_odds = pick_idle_odds();
			if ($urandom_range(0, 14) == 0)
				wait_for_replies();
			if ($urandom_range(0, 99) < 85)
				run_unwind_frame();
			else
				drive_word(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom());
		end

		wait_for_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.failures == 0)
			$display("[arm_unwind_opcode_engine_unit] OK");
		else
			$display("[arm_unwind_opcode_engine_unit] ERROR");
		$finish;
	end

endmodule
